[hw/rtl/mft_pkg.sv]
// Package: shared types, constants and register indexes of the motor feedback tracker.
`timescale 1ns / 1ps
`default_nettype none
package mft_pkg;

  localparam int unsigned MOTORS_PER_BUS_DEF = 11;
  localparam int unsigned ID_W       = 11;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned TURN_W     = 16;
  localparam int unsigned TOTAL_W    = 30;
  localparam int unsigned TURN_SHIFT = 13;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned S_DATA_W   = 80;
  localparam int unsigned M_DATA_W   = 112;

  localparam logic [ID_W-1:0]    BASE_ID_RST   = 11'd513;
  localparam logic [ANGLE_W-1:0] WRAP_LOW_RST  = 16'd2000;
  localparam logic [ANGLE_W-1:0] WRAP_HIGH_RST = 16'd6200;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = -16'sh8000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_ID   = 2'd0,
    REG_WRAP_LOW  = 2'd1,
    REG_WRAP_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]    base_id;
    logic [ANGLE_W-1:0] wrap_low;
    logic [ANGLE_W-1:0] wrap_high;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic [7:0]      b4;
    logic [7:0]      b5;
    logic [7:0]      b6;
    logic            bus;
  } frame_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               bus;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        speed;
    logic [15:0]        current_raw;
    logic [7:0]         temperature;
  } meas_t;

endpackage
`default_nettype wire

[hw/rtl/motor_feedback_multiturn_tracker_core.sv]
// Top level: motor feedback decoder with multi-turn angle tracking.
// Takes one CAN frame word per clock and returns one result word per frame that hits the
// motor id range with a non-empty measurement; other frames are dropped silently. A frame
// passes the input register, then the result register. Throughput is one word per cycle
// while downstream accepts, with the per-slot angle and turn table read, updated and written
// back for each word. While downstream stalls, dropped frames keep draining and a hit waits
// in the input register until the result register is free.
// Reset clears the table to zero turns and zero previous angle. Write configuration only
// while no frames are in flight.
`timescale 1ns / 1ps
`default_nettype none
module motor_feedback_multiturn_tracker_core #(
  parameter int unsigned MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // frame_id[10:0], byte0..byte7 in [18:11]..[74:67], zero pad [79:75]
  input  logic [mft_pkg::S_DATA_W-1:0]       s_tdata,
  // bus
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // motor_index[3:0], angle[19:4], speed[35:20], current_raw[51:36], temperature[59:52],
  // turns[75:60], wide_angle[105:76], zero pad [111:106]
  output logic [mft_pkg::M_DATA_W-1:0]       m_tdata,
  // out_bus
  output logic                               m_tuser,
  input  logic                               cfg_we,
  input  logic [mft_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mft_pkg::CFG_W-1:0]          cfg_wdata
);
  import mft_pkg::*;

  cfg_t   cfg;
  frame_t frame;
  logic   frame_valid;
  meas_t  meas;
  logic   out_free;
  logic   advance;
  logic   emit;
  logic signed [TURN_W-1:0]  turns;
  logic signed [TOTAL_W-1:0] wide_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_id   <= BASE_ID_RST;
      cfg.wrap_low  <= WRAP_LOW_RST;
      cfg.wrap_high <= WRAP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE_ID:   cfg.base_id   <= cfg_wdata[ID_W-1:0];
        REG_WRAP_LOW:  cfg.wrap_low  <= cfg_wdata;
        REG_WRAP_HIGH: cfg.wrap_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free = !m_tvalid || m_tready;
    advance  = frame_valid && (out_free || !meas.hit);
    emit     = advance && meas.hit;
    s_tready = !frame_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (s_tready) begin
      frame_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      frame.frame_id <= s_tdata[10:0];
      frame.b0       <= s_tdata[18:11];
      frame.b1       <= s_tdata[26:19];
      frame.b2       <= s_tdata[34:27];
      frame.b3       <= s_tdata[42:35];
      frame.b4       <= s_tdata[50:43];
      frame.b5       <= s_tdata[58:51];
      frame.b6       <= s_tdata[66:59];
      frame.bus      <= s_tuser;
    end
  end

  mft_decode #(
    .MOTORS_PER_BUS(MOTORS_PER_BUS)
  ) u_decode (
    .frame   (frame),
    .base_id (cfg.base_id),
    .meas    (meas)
  );

  mft_turn_table #(
    .MOTORS_PER_BUS(MOTORS_PER_BUS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .meas       (meas),
    .cfg        (cfg),
    .update     (emit),
    .turns      (turns),
    .wide_angle (wide_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {(M_DATA_W-106)'(0), wide_angle, turns, meas.temperature,
                  meas.current_raw, meas.speed, meas.angle, meas.slot};
      m_tuser <= meas.bus;
    end
  end

  logic unused_pad;
  assign unused_pad = ^{s_tdata[S_DATA_W-1:67]};

endmodule
`default_nettype wire

[hw/rtl/mft_decode.sv]
// Frame decoder: id range match, payload unpack and empty-frame detection.
`timescale 1ns / 1ps
`default_nettype none
module mft_decode #(
  parameter int unsigned MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
  input  mft_pkg::frame_t frame,
  input  logic [mft_pkg::ID_W-1:0] base_id,
  output mft_pkg::meas_t  meas
);
  import mft_pkg::*;

  logic [ID_W:0] diff;
  logic          in_range;
  logic          empty;

  always_comb begin
    diff     = {1'b0, frame.frame_id} - {1'b0, base_id};
    in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MOTORS_PER_BUS));
    meas.angle       = {frame.b0, frame.b1};
    meas.speed       = {frame.b2, frame.b3};
    meas.current_raw = {frame.b4, frame.b5};
    meas.temperature = frame.b6;
    empty = (meas.angle == '0) && (meas.speed == '0) && (meas.current_raw == '0)
            && (meas.temperature == '0);
    meas.hit  = in_range && !empty;
    meas.slot = diff[SLOT_W-1:0];
    meas.bus  = frame.bus;
  end

endmodule
`default_nettype wire

[hw/rtl/mft_turn_table.sv]
// Per-slot angle and turn table with wrap detection and saturating turn update.
`timescale 1ns / 1ps
`default_nettype none
module mft_turn_table #(
  parameter int unsigned MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mft_pkg::meas_t                      meas,
  input  mft_pkg::cfg_t                       cfg,
  input  logic                                update,
  output logic signed [mft_pkg::TURN_W-1:0]   turns,
  output logic signed [mft_pkg::TOTAL_W-1:0]  wide_angle
);
  import mft_pkg::*;

  localparam int unsigned SLOTS   = 2 * MOTORS_PER_BUS;
  localparam int unsigned ENTRY_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ANGLE_W-1:0]       prev_angle [SLOTS];
  logic signed [TURN_W-1:0] turn_cnt   [SLOTS];

  logic [ENTRY_W-1:0]       entry;
  logic [ANGLE_W-1:0]       prev;
  logic signed [TURN_W-1:0] cur;
  logic                     wrap_down;
  logic                     wrap_up;

  always_comb begin
    entry = meas.bus ? (ENTRY_W'(MOTORS_PER_BUS) + ENTRY_W'(meas.slot))
                     : ENTRY_W'(meas.slot);
    prev  = prev_angle[entry];
    cur   = turn_cnt[entry];
    wrap_down = (prev < cfg.wrap_low) && (meas.angle > cfg.wrap_high);
    wrap_up   = (prev > cfg.wrap_high) && (meas.angle < cfg.wrap_low);
    turns = cur;
    if (wrap_down) begin
      if (cur != TURN_MIN) turns = cur - TURN_W'(1);
    end else if (wrap_up) begin
      if (cur != TURN_MAX) turns = cur + TURN_W'(1);
    end
    wide_angle = {turns[TURN_W-1], turns, TURN_SHIFT'(0)}
                 + {(TOTAL_W-ANGLE_W)'(0), meas.angle};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        prev_angle[i] <= '0;
        turn_cnt[i]   <= '0;
      end
    end else if (update) begin
      prev_angle[entry] <= meas.angle;
      turn_cnt[entry]   <= turns;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mft_checker.sv]
// Port checker for the motor feedback tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mft_checker #(
  parameter int unsigned MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [mft_pkg::M_DATA_W-1:0] m_tdata
);
  import mft_pkg::*;

  logic [29:0] expect_total;
  assign expect_total = {m_tdata[75], m_tdata[75:60], 13'd0} + {14'd0, m_tdata[19:4]};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata[3:0]} < (SLOT_W+1)'(MOTORS_PER_BUS))
    else $error("motor index out of range");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[105:76] == expect_total)
    else $error("total angle does not match angle and turns");

  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[59:4] != '0)
    else $error("empty measurement emitted");

endmodule

bind motor_feedback_multiturn_tracker_core mft_checker #(
  .MOTORS_PER_BUS(MOTORS_PER_BUS)
) u_mft_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
